@@ hw/rtl/tilt_complementary_filter_pd_assert.svh @@
// Assertion macros used by the checker file of the tilt filter block.
// Needs nothing else; include by bare file name.
`ifndef TILT_COMPLEMENTARY_FILTER_PD_ASSERT_SVH
`define TILT_COMPLEMENTARY_FILTER_PD_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCF_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/tcf_pkg.sv @@
// Shared types and constants of the tilt complementary filter block.
// No dependencies; used by the CORDIC unit and the top level.
`default_nettype none

package tcf_pkg;

  // CORDIC angle accumulator, degrees in Q16
  localparam int ZW      = 26;
  // CORDIC x/y datapath width
  localparam int XW      = 28;
  // arctangent table
  localparam int TAB_LEN = 24;
  localparam int TAB_IW  = 5;
  // gain-side operand width of the shared multiplier
  localparam int GW      = 19;

  // configuration port
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 18;

  localparam logic signed [ZW-1:0] ANGLE_180 = 26'sd11796480;
  localparam logic [16:0] BLEND_ONE = 17'd65536;
  localparam logic [9:0]  DRIVE_MAX = 10'd1000;

  // reset values of the registers
  localparam logic [16:0] BLEND_WEIGHT_RST    = 17'd64225;
  localparam logic [15:0] RATE_STEP_SCALE_RST = 16'd16777;
  localparam logic [17:0] PROP_GAIN_RST       = 18'd32768;
  localparam logic [17:0] DERIV_GAIN_RST      = 18'd655;
  localparam logic [9:0]  DRIVE_LIMIT_RST     = 10'd100;

  typedef enum logic [CFG_IW-1:0] {
    REG_BLEND_WEIGHT    = 3'd0,
    REG_RATE_STEP_SCALE = 3'd1,
    REG_PROP_GAIN       = 3'd2,
    REG_DERIV_GAIN      = 3'd3,
    REG_DRIVE_LIMIT     = 3'd4
  } cfg_reg_t;

  // status of the CORDIC unit toward the sequencer
  typedef struct packed {
    logic                 done;
    logic signed [ZW-1:0] angle;
  } cord_stat_t;

  // atan(2^-i) in degrees, Q16
  function automatic logic signed [ZW-1:0] atan_lookup(input logic [TAB_IW-1:0] idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      5'd0:    v = 26'sd2949120;
      5'd1:    v = 26'sd1740967;
      5'd2:    v = 26'sd919879;
      5'd3:    v = 26'sd466945;
      5'd4:    v = 26'sd234379;
      5'd5:    v = 26'sd117304;
      5'd6:    v = 26'sd58666;
      5'd7:    v = 26'sd29335;
      5'd8:    v = 26'sd14668;
      5'd9:    v = 26'sd7334;
      5'd10:   v = 26'sd3667;
      5'd11:   v = 26'sd1833;
      5'd12:   v = 26'sd917;
      5'd13:   v = 26'sd458;
      5'd14:   v = 26'sd229;
      5'd15:   v = 26'sd115;
      5'd16:   v = 26'sd57;
      5'd17:   v = 26'sd29;
      5'd18:   v = 26'sd14;
      5'd19:   v = 26'sd7;
      5'd20:   v = 26'sd4;
      5'd21:   v = 26'sd2;
      5'd22:   v = 26'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tcf_in_if.sv @@
// Input channel of the tilt filter: one IMU sample plus target per beat.
// No dependencies.
`default_nettype none

interface tcf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_z;
  logic signed [15:0] gyro_y;
  logic signed [16:0] balance_target;

  modport source (output valid, output accel_x, output accel_z, output gyro_y,
                  output balance_target, input ready);
  modport sink   (input valid, input accel_x, input accel_z, input gyro_y,
                  input balance_target, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/tcf_out_if.sv @@
// Output channel of the tilt filter: pitch, rate and balance drive per beat.
// No dependencies.
`default_nettype none

interface tcf_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] pitch_estimate;
  logic signed [15:0] pitch_rate_out;
  logic signed [10:0] balance_drive;

  modport source (output valid, output pitch_estimate, output pitch_rate_out,
                  output balance_drive, input ready);
  modport sink   (input valid, input pitch_estimate, input pitch_rate_out,
                  input balance_drive, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/tcf_cordic.sv @@
// Iterative vectoring CORDIC: atan2(y, x) in degrees Q16, one rotation per cycle.
// Depends on tcf_pkg (widths, arctangent table, status struct).
`default_nettype none

module tcf_cordic #(
  parameter int STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [16:0] x_in,
  input  wire logic signed [16:0] y_in,
  output tcf_pkg::cord_stat_t     stat
);

  localparam int CW = $clog2(STEPS + 1);

  logic signed [tcf_pkg::XW-1:0] x;
  logic signed [tcf_pkg::XW-1:0] y;
  logic signed [tcf_pkg::ZW-1:0] z;
  logic [CW-1:0]                 iter;
  logic                          busy;
  logic                          done;
  logic                          zero_vec;

  // pre-rotation by 180 degrees for negative x
  logic                          x_neg;
  logic signed [16:0]            xs;
  logic signed [16:0]            ys;
  logic signed [tcf_pkg::ZW-1:0] z0;
  // one micro-rotation
  logic signed [tcf_pkg::XW-1:0] xsh;
  logic signed [tcf_pkg::XW-1:0] ysh;
  logic signed [tcf_pkg::ZW-1:0] step_ang;

  always_comb begin
    x_neg = x_in < 0;
    xs    = x_neg ? 17'sd0 - x_in : x_in;
    ys    = x_neg ? 17'sd0 - y_in : y_in;
    if (x_neg) begin
      z0 = (y_in >= 0) ? tcf_pkg::ANGLE_180 : -tcf_pkg::ANGLE_180;
    end else begin
      z0 = '0;
    end
    xsh      = x >>> iter;
    ysh      = y >>> iter;
    step_ang = tcf_pkg::atan_lookup(tcf_pkg::TAB_IW'(iter));
  end

  // control: busy while rotating, done holds until the next start
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      iter <= '0;
    end else if (busy) begin
      iter <= iter + 1'b1;
      if (iter == CW'(STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      x        <= {{(tcf_pkg::XW - 25){xs[16]}}, xs, 8'd0};
      y        <= {{(tcf_pkg::XW - 25){ys[16]}}, ys, 8'd0};
      z        <= z0;
      zero_vec <= (x_in == 0) && (y_in == 0);
    end else if (busy) begin
      if (y > 0) begin
        x <= x + ysh;
        y <= y - xsh;
        z <= z + step_ang;
      end else begin
        x <= x - ysh;
        y <= y + xsh;
        z <= z - step_ang;
      end
    end
  end

  assign stat.done  = done;
  assign stat.angle = zero_vec ? '0 : z;

endmodule

`default_nettype wire

@@ hw/rtl/tcf_mul.sv @@
// Shared signed multiplier with a registered product and load enable.
// No dependencies.
`default_nettype none

module tcf_mul #(
  parameter int AW = 19,
  parameter int BW = 20
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic signed [AW-1:0]     a,
  input  wire logic signed [BW-1:0]     b,
  output logic signed [AW+BW-1:0]       p
);

  // product holds while en is low
  always_ff @(posedge clk) begin
    if (en) begin
      p <= a * b;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/tilt_complementary_filter_pd.sv @@
// Tilt complementary filter with PD balance drive.
// Takes one sample at a time: a new input beat is accepted only in idle, after the
// previous result has gone into the output register; the five multiplies share one
// registered multiplier.
// Reset (synchronous): pitch cleared to zero, registers to defaults, channels idle.
`default_nettype none

module tilt_complementary_filter_pd #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         wr_en,
  input  wire logic [tcf_pkg::CFG_IW-1:0]   wr_index,
  input  wire logic [tcf_pkg::CFG_DW-1:0]   wr_data,
  tcf_in_if.sink                            in_ch,
  tcf_out_if.source                         out_ch
);

  localparam int AW = ((ANGLE_FRAC_BITS + 10 > 17) ? ANGLE_FRAC_BITS + 10 : 17) + 1;
  localparam int BW = AW + 1;
  localparam int PW = tcf_pkg::GW + BW;
  localparam int SW = PW + 1;
  localparam int DW = PW + ANGLE_FRAC_BITS + 2;

  localparam logic signed [PW-1:0] RND_RATE  = PW'(1 << 15);
  localparam logic signed [SW-1:0] RND_BLEND = SW'(1 << 15);
  localparam logic signed [DW-1:0] RND_DRIVE = DW'(1 << (15 + ANGLE_FRAC_BITS));
  localparam logic signed [tcf_pkg::ZW-1:0] RND_ACC = tcf_pkg::ZW'(1 << (15 - ANGLE_FRAC_BITS));
  localparam logic signed [SW-1:0] PMAX      = SW'(180 << ANGLE_FRAC_BITS);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RATE  = 9'b000000010,
    S_KD    = 9'b000000100,
    S_PRED  = 9'b000001000,
    S_WAIT  = 9'b000010000,
    S_ACC   = 9'b000100000,
    S_BLEND = 9'b001000000,
    S_KP    = 9'b010000000,
    S_DRIVE = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  // configuration registers
  logic [16:0] blend_weight;
  logic [15:0] rate_step_scale;
  logic [17:0] prop_gain;
  logic [17:0] deriv_gain;
  logic [9:0]  drive_limit;

  // per-item and filter state
  logic signed [15:0]   gyro;
  logic signed [16:0]   target;
  logic signed [AW-1:0] pitch;
  logic signed [AW-1:0] pred;
  logic signed [PW-1:0] kd_prod;
  logic signed [PW-1:0] wp_prod;

  // output register
  logic               out_valid;
  logic signed [16:0] out_pitch;
  logic signed [15:0] out_rate;
  logic signed [10:0] out_drive;

  logic in_beat;
  logic out_free;

  // CORDIC and multiplier hookup
  logic                      cord_start;
  logic signed [16:0]        cord_x;
  logic signed [16:0]        cord_y;
  tcf_pkg::cord_stat_t       cord_stat;
  logic                      mul_en;
  logic signed [tcf_pkg::GW-1:0] mul_a;
  logic signed [BW-1:0]      mul_b;
  logic signed [PW-1:0]      mul_p;

  // arithmetic around the multiplier
  logic [16:0]          w_eff;
  logic [16:0]          w_comp;
  logic [9:0]           lim;
  logic signed [DW-1:0] lim_s;
  logic signed [PW-1:0] rate_sum;
  logic signed [PW-1:0] rate_inc;
  logic signed [AW-1:0] pred_next;
  logic signed [tcf_pkg::ZW-1:0] acc_sum;
  logic signed [tcf_pkg::ZW-1:0] acc_shift;
  logic signed [AW-1:0] acc_q;
  logic signed [SW-1:0] blend_sum;
  logic signed [SW-1:0] blend_q;
  logic signed [AW-1:0] pitch_next;
  logic signed [BW-1:0] err;
  logic signed [DW-1:0] drive_sum;
  logic signed [DW-1:0] drive_q;
  logic signed [DW-1:0] drive_sat;

  assign in_ch.ready = (state == S_IDLE);
  assign in_beat     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid || out_ch.ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      blend_weight    <= tcf_pkg::BLEND_WEIGHT_RST;
      rate_step_scale <= tcf_pkg::RATE_STEP_SCALE_RST;
      prop_gain       <= tcf_pkg::PROP_GAIN_RST;
      deriv_gain      <= tcf_pkg::DERIV_GAIN_RST;
      drive_limit     <= tcf_pkg::DRIVE_LIMIT_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        tcf_pkg::REG_BLEND_WEIGHT:    blend_weight    <= wr_data[16:0];
        tcf_pkg::REG_RATE_STEP_SCALE: rate_step_scale <= wr_data[15:0];
        tcf_pkg::REG_PROP_GAIN:       prop_gain       <= wr_data[17:0];
        tcf_pkg::REG_DERIV_GAIN:      deriv_gain      <= wr_data[17:0];
        tcf_pkg::REG_DRIVE_LIMIT:     drive_limit     <= wr_data[9:0];
        default: ;
      endcase
    end
  end

  // CORDIC runs atan2(-accel_x, accel_z) from the input beat on
  assign cord_start = in_beat;
  assign cord_x     = {in_ch.accel_z[15], in_ch.accel_z};
  assign cord_y     = 17'sd0 - $signed({in_ch.accel_x[15], in_ch.accel_x});

  tcf_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cord_start),
    .x_in  (cord_x),
    .y_in  (cord_y),
    .stat  (cord_stat)
  );

  // clamped register views
  always_comb begin
    w_eff  = (blend_weight > tcf_pkg::BLEND_ONE) ? tcf_pkg::BLEND_ONE : blend_weight;
    w_comp = tcf_pkg::BLEND_ONE - w_eff;
    lim    = (drive_limit > tcf_pkg::DRIVE_MAX) ? tcf_pkg::DRIVE_MAX : drive_limit;
    lim_s  = DW'($signed({1'b0, lim}));
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    err    = BW'(target) - BW'(pitch);
    unique case (state)
      S_RATE: begin
        mul_a = $signed({3'b000, rate_step_scale});
        mul_b = BW'(gyro);
      end
      S_KD: begin
        mul_a = $signed({1'b0, deriv_gain});
        mul_b = BW'(gyro);
      end
      S_PRED: begin
        mul_a = $signed({2'b00, w_eff});
        mul_b = BW'(pred);
      end
      S_ACC: begin
        mul_a = $signed({2'b00, w_comp});
        mul_b = BW'(acc_q);
      end
      S_KP: begin
        mul_a = $signed({1'b0, prop_gain});
        mul_b = err;
      end
      default: mul_en = 1'b0;
    endcase
  end

  tcf_mul #(
    .AW (tcf_pkg::GW),
    .BW (BW)
  ) u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // rounding, blend and saturation
  always_comb begin
    rate_sum  = mul_p + RND_RATE;
    rate_inc  = rate_sum >>> 16;
    pred_next = pitch + AW'(rate_inc);

    acc_sum   = cord_stat.angle + RND_ACC;
    acc_shift = acc_sum >>> (16 - ANGLE_FRAC_BITS);
    acc_q     = AW'(acc_shift);

    blend_sum = SW'(wp_prod) + SW'(mul_p) + RND_BLEND;
    blend_q   = blend_sum >>> 16;
    priority if (blend_q > PMAX) begin
      pitch_next = AW'(PMAX);
    end else if (blend_q < -PMAX) begin
      pitch_next = AW'(-PMAX);
    end else begin
      pitch_next = AW'(blend_q);
    end

    drive_sum = RND_DRIVE - DW'(mul_p) - (DW'(kd_prod) <<< ANGLE_FRAC_BITS);
    drive_q   = drive_sum >>> (16 + ANGLE_FRAC_BITS);
    priority if (drive_q > lim_s) begin
      drive_sat = lim_s;
    end else if (drive_q < -lim_s) begin
      drive_sat = -lim_s;
    end else begin
      drive_sat = drive_q;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_beat) state_next = S_RATE;
      S_RATE:  state_next = S_KD;
      S_KD:    state_next = S_PRED;
      S_PRED:  state_next = S_WAIT;
      S_WAIT:  if (cord_stat.done) state_next = S_ACC;
      S_ACC:   state_next = S_BLEND;
      S_BLEND: state_next = S_KP;
      S_KP:    state_next = S_DRIVE;
      S_DRIVE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pitch <= '0;
    end else begin
      state <= state_next;
      if (state == S_BLEND) begin
        pitch <= pitch_next;
      end
    end
  end

  // item payload registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      gyro   <= in_ch.gyro_y;
      target <= in_ch.balance_target;
    end
    if (state == S_KD) begin
      pred <= pred_next;
    end
    if (state == S_PRED) begin
      kd_prod <= mul_p;
    end
    if (state == S_ACC) begin
      wp_prod <= mul_p;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DRIVE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DRIVE && out_free) begin
      out_pitch <= pitch[16:0];
      out_rate  <= gyro;
      out_drive <= drive_sat[10:0];
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.pitch_estimate = out_pitch;
  assign out_ch.pitch_rate_out = out_rate;
  assign out_ch.balance_drive  = out_drive;

endmodule

`default_nettype wire

@@ hw/rtl/tcf_checker.sv @@
// Port-level checker for the tilt filter top level, bound in below.
// Depends on tilt_complementary_filter_pd_assert.svh and the top level.
`default_nettype none

`include "tilt_complementary_filter_pd_assert.svh"

module tcf_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [16:0] pitch_estimate,
  input wire logic signed [15:0] pitch_rate_out,
  input wire logic signed [10:0] balance_drive
);

  // a stalled result beat stays up with its payload
  `TCF_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "result beat dropped while stalled")
  `TCF_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(pitch_estimate) && $stable(pitch_rate_out) && $stable(balance_drive), "result payload changed while stalled")

  // drive never exceeds the hard bound
  `TCF_ASSERT_SAME(a_drive_bound, clk, rst, out_valid, (balance_drive <= 11'sd1000) && (balance_drive >= -11'sd1000), "balance drive out of bound")

  // one sample at a time: busy right after an input beat
  `TCF_ASSERT_NEXT(a_busy_after_beat, clk, rst, in_valid && in_ready, !in_ready, "input taken while busy")

endmodule

bind tilt_complementary_filter_pd tcf_checker u_tcf_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .pitch_estimate (out_ch.pitch_estimate),
  .pitch_rate_out (out_ch.pitch_rate_out),
  .balance_drive  (out_ch.balance_drive)
);

`default_nettype wire
